FILE: src/sotp_pkg.sv
package sotp_pkg;

  localparam int MSG_BYTES = 96;
  localparam int ADDR_W    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int LANES     = 8;
  localparam int COEFF_W   = 16;
  localparam int IDX_W     = 7;
  localparam int KEY_W     = 8;
  localparam int CMP_W     = 9;
  localparam int IN_DATA_W = 152;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic msg_bit;
    logic over;
  } lane_res_t;

endpackage

FILE: src/sotp_lane.sv
module sotp_lane
  import sotp_pkg::*;
(
  input  logic [COEFF_W-1:0] coeff,
  input  logic               key_hi_bit,
  input  logic               key_lo_bit,
  output lane_res_t          res
);

  logic [COEFF_W-1:0] sum;

  // wrap modulo 2^16; any sum above one is a failure
  assign sum         = coeff + COEFF_W'(key_hi_bit);
  assign res.over    = |sum[COEFF_W-1:1];
  assign res.msg_bit = sum[0] ^ key_lo_bit;

endmodule

FILE: src/sotp_merge.sv
module sotp_merge
  import sotp_pkg::*;
(
  input  lane_res_t [LANES-1:0] lane_res,
  output logic [LANES-1:0]      msg_byte,
  output logic                  fail_any
);

  always_comb begin
    fail_any = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      msg_byte[j] = lane_res[j].msg_bit;
      fail_any    = fail_any | lane_res[j].over;
    end
  end

endmodule

FILE: src/sotp_message_decoder_top.sv
// SOTP message decoder.
// Input channel s_axis: tuser selects the request (push a coefficient group
// or read one message byte); tdata carries byte index, both pad bytes and
// eight 16-bit coefficients. Eight lanes decode one bit each from the
// coefficient and pad bits; a merge stage builds the byte and the failure
// indication. A push stores the byte at its index if below 96 and updates
// the failure mark (cleared first by a push at index 0); a read returns the
// stored byte, or zero while the mark is set or the index is 96 or above.
// Output channel m_axis: tdata is the message byte (zero on push), tuser the
// failure mark after the item. One result per item.
// Steps: a push passes the lane capture and execute steps and the done
// step to the output register; a read also passes the registered memory
// read step. One item is in work at a time, so the block takes a new item
// only after the last one has left the done step.
// The output register holds a result while the receiver stalls; the next
// item is accepted meanwhile and waits in the done step for the register.
// Reset clears the failure mark and all handshake state; the message store
// is not cleared and needs no clearing pass.
module sotp_message_decoder_top
  import sotp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // byte_index[6:0], key_low_byte[14:7], key_high_byte[22:15],
  // coeff_0[38:23] .. coeff_7[150:135], zero pad [151]
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // msg_byte[7:0]
  output logic [7:0]           m_axis_tdata,
  // decode_failed
  output logic                 m_axis_tuser
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ, ST_DONE} state_t;

  localparam int KLO_LSB  = IDX_W;
  localparam int KHI_LSB  = IDX_W + KEY_W;
  localparam int COEF_LSB = IDX_W + 2 * KEY_W;

  state_t            state;
  logic              req;
  logic [IDX_W-1:0]  idx;
  logic [LANES-1:0]  dec_byte;
  logic              dec_fail;
  logic              mark;
  logic [7:0]        res_data;
  logic              res_fail;
  logic [7:0]        rd_data;
  logic [7:0]        mem [MSG_BYTES];

  logic [IDX_W-1:0]  in_idx;
  logic [KEY_W-1:0]  in_klo;
  logic [KEY_W-1:0]  in_khi;
  lane_res_t [LANES-1:0] lane_res;
  logic [LANES-1:0]  merged_byte;
  logic              merged_fail;
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic              mark_next;
  logic              accept;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_klo = s_axis_tdata[KLO_LSB +: KEY_W];
  assign in_khi = s_axis_tdata[KHI_LSB +: KEY_W];

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    sotp_lane u_lane (
      .coeff      (s_axis_tdata[COEF_LSB + j*COEFF_W +: COEFF_W]),
      .key_hi_bit (in_khi[j]),
      .key_lo_bit (in_klo[j]),
      .res        (lane_res[j])
    );
  end

  sotp_merge u_merge (
    .lane_res (lane_res),
    .msg_byte (merged_byte),
    .fail_any (merged_fail)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = CMP_W'(idx) < CMP_W'(MSG_BYTES);
  assign addr          = ADDR_W'(idx);
  assign mark_next     = ((idx == '0) ? 1'b0 : mark) | dec_fail;

  // capture lane results with the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= s_axis_tuser;
      idx      <= in_idx;
      dec_byte <= merged_byte;
      dec_fail <= merged_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && req == REQ_PUSH && in_range) begin
      mem[addr] <= dec_byte;
    end
    if (state == ST_EXEC) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mark          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the done step reloads the register itself when it is taken
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (req == REQ_PUSH) begin
            mark     <= mark_next;
            res_data <= '0;
            res_fail <= mark_next;
            state    <= ST_DONE;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          res_data <= (mark || !in_range) ? 8'd0 : rd_data;
          res_fail <= mark;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_data;
            m_axis_tuser  <= res_fail;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/sotp_checker.sv
module sotp_checker
  import sotp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [7:0]           m_axis_tdata,
  input logic                 m_axis_tuser
);

  // one item in work at a time: input closes right after an accept
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready after accept");

  // a failed message never leaks data
  a_fail_masks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("data shown while failure mark set");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a rising result needs the input to have been closed before it, as while an item is in work
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready, 1) && !$past(s_axis_tready, 2))
    else $error("result without an item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind sotp_message_decoder_top sotp_checker u_sotp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
